[hdl/rotary_encoder_button_events_core_assert.svh]
// Assertion macros shared by the encoder/button event block.
// Expects signals named clk and rst in the scope where a macro is used.
`ifndef ROTARY_ENCODER_BUTTON_EVENTS_CORE_ASSERT_SVH
`define ROTARY_ENCODER_BUTTON_EVENTS_CORE_ASSERT_SVH

// Checked only outside reset.
`define REB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Checked on every edge, reset included.
`define REB_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

[hdl/reb_pkg.sv]
// Package for the rotary encoder / button event block.
// Types, codes, reset values and helpers; no dependencies.
`timescale 1ns / 1ps

package reb_pkg;

  localparam int TURN_COUNT_BITS = 16;
  localparam int HOLD_TIMER_BITS = 16;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // opcodes
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_POLL   = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;
  localparam logic [1:0] OP_TAKE   = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CLICK_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PANIC     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VERY_LONG = 2'd3;

  localparam logic [CFG_W-1:0] CLICK_MIN_RST = 16'd50;
  localparam logic [CFG_W-1:0] LONG_RST      = 16'd1000;
  localparam logic [CFG_W-1:0] PANIC_RST     = 16'd3000;
  localparam logic [CFG_W-1:0] VERY_LONG_RST = 16'd5000;

  // event codes
  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_CW        = 3'd1;
  localparam logic [2:0] EV_CCW       = 3'd2;
  localparam logic [2:0] EV_CLICK     = 3'd3;
  localparam logic [2:0] EV_LONG      = 3'd4;
  localparam logic [2:0] EV_PANIC     = 3'd5;
  localparam logic [2:0] EV_VERY_LONG = 3'd6;

  localparam logic [1:0] PHASE_DETENT = 2'b11;

  typedef logic signed [TURN_COUNT_BITS-1:0] turns_t;
  typedef logic [HOLD_TIMER_BITS-1:0]        timer_t;

  localparam turns_t TURN_MAX = turns_t'({1'b0, {(TURN_COUNT_BITS-1){1'b1}}});
  localparam turns_t TURN_MIN = turns_t'({1'b1, {(TURN_COUNT_BITS-1){1'b0}}});
  localparam turns_t TURN_ONE = turns_t'(1);
  localparam timer_t TIMER_MAX = '1;
  localparam timer_t TIMER_ONE = timer_t'(1);

  typedef struct packed {
    logic       fire;
    logic [1:0] opcode;
    logic       enc_a;
    logic       enc_b;
    logic       button_level;
  } cmd_t;

  typedef struct packed {
    logic [CFG_W-1:0] click_min_ms;
    logic [CFG_W-1:0] long_ms;
    logic [CFG_W-1:0] panic_ms;
    logic [CFG_W-1:0] very_long_ms;
  } cfg_t;

  typedef struct packed {
    logic pos;
    logic neg;
  } turn_stat_t;

  // Quadrature step for {previous phase, current phase}.
  function automatic logic signed [1:0] gray_step(input logic [3:0] idx);
    logic signed [1:0] s;
    unique case (idx) inside
      4'd2, 4'd4, 4'd11, 4'd13: s = 2'sd1;
      4'd1, 4'd7, 4'd8, 4'd14:  s = -2'sd1;
      default:                  s = 2'sd0;
    endcase
    return s;
  endfunction

  function automatic logic [15:0] sat16(input timer_t t);
    logic [31:0] ext;
    ext = 32'(t);
    return (|ext[31:16]) ? 16'hFFFF : ext[15:0];
  endfunction

  function automatic logic timer_ge(input timer_t t, input logic [CFG_W-1:0] th);
    return 32'(t) >= 32'(th);
  endfunction

endpackage

[hdl/reb_turns.sv]
// Quadrature decode: phase tracking, step accumulator, pending turn count.
// Depends on reb_pkg.
`timescale 1ns / 1ps

module reb_turns (
  input  logic               clk,
  input  logic               rst,
  input  reb_pkg::cmd_t      cmd,
  input  logic               consume,
  output reb_pkg::turn_stat_t stat
);
  import reb_pkg::*;

  logic [1:0]        prev_phase, prev_phase_next;
  logic signed [7:0] step_sum, step_sum_next;
  turns_t            pending_turns, pending_turns_next;

  logic [1:0]        cur;
  logic signed [1:0] step;
  logic signed [7:0] sum_sat;

  always_comb begin
    cur  = {cmd.enc_a, cmd.enc_b};
    step = gray_step({prev_phase, cur});
    if (step > 0 && step_sum == 8'sd127) begin
      sum_sat = step_sum;
    end else if (step < 0 && step_sum == -8'sd128) begin
      sum_sat = step_sum;
    end else begin
      sum_sat = step_sum + $signed({{6{step[1]}}, step});
    end

    prev_phase_next    = prev_phase;
    step_sum_next      = step_sum;
    pending_turns_next = pending_turns;

    if (cmd.fire && cmd.opcode == OP_SAMPLE) begin
      prev_phase_next = cur;
      step_sum_next   = sum_sat;
      // arriving at detent closes one turn
      if (cur == PHASE_DETENT && prev_phase != PHASE_DETENT) begin
        if (sum_sat > 0 && pending_turns < TURN_MAX) begin
          pending_turns_next = pending_turns + TURN_ONE;
        end else if (sum_sat < 0 && pending_turns > TURN_MIN) begin
          pending_turns_next = pending_turns - TURN_ONE;
        end
        step_sum_next = '0;
      end
    end else if (consume) begin
      if (pending_turns > 0) begin
        pending_turns_next = pending_turns - TURN_ONE;
      end else if (pending_turns < 0) begin
        pending_turns_next = pending_turns + TURN_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_phase    <= PHASE_DETENT;
      step_sum      <= '0;
      pending_turns <= '0;
    end else begin
      prev_phase    <= prev_phase_next;
      step_sum      <= step_sum_next;
      pending_turns <= pending_turns_next;
    end
  end

  assign stat.pos = pending_turns > 0;
  assign stat.neg = pending_turns < 0;

endmodule

[hdl/reb_button.sv]
// Button hold timer, press classifier and one-deep event slot.
// Depends on reb_pkg.
`timescale 1ns / 1ps

module reb_button (
  input  logic                clk,
  input  logic                rst,
  input  reb_pkg::cmd_t       cmd,
  input  reb_pkg::cfg_t       cfg,
  input  reb_pkg::turn_stat_t stat,
  output logic                consume,
  output logic [2:0]          event_res,
  output logic                pressed,
  output logic [15:0]         press_ms
);
  import reb_pkg::*;

  logic [2:0] queued_event, queued_event_next;
  logic       button_held, button_held_next;
  timer_t     hold_timer, hold_timer_next;
  logic       long_done, long_done_next;
  logic       panic_done, panic_done_next;
  logic       very_long_done, very_long_done_next;
  logic       down;

  always_comb begin
    queued_event_next   = queued_event;
    button_held_next    = button_held;
    hold_timer_next     = hold_timer;
    long_done_next      = long_done;
    panic_done_next     = panic_done;
    very_long_done_next = very_long_done;
    consume             = 1'b0;
    event_res           = EV_NONE;
    down                = !cmd.button_level;

    if (cmd.fire) begin
      case (cmd.opcode)
        OP_POLL: begin
          if (queued_event == EV_NONE && (stat.pos || stat.neg)) begin
            // a pending turn wins the poll
            consume           = 1'b1;
            queued_event_next = stat.pos ? EV_CW : EV_CCW;
          end else if (!button_held && down) begin
            button_held_next    = 1'b1;
            hold_timer_next     = '0;
            long_done_next      = 1'b0;
            panic_done_next     = 1'b0;
            very_long_done_next = 1'b0;
          end else if (button_held && down) begin
            if (!very_long_done && timer_ge(hold_timer, cfg.very_long_ms)) begin
              queued_event_next   = EV_VERY_LONG;
              very_long_done_next = 1'b1;
            end else if (!panic_done && timer_ge(hold_timer, cfg.panic_ms)) begin
              queued_event_next = EV_PANIC;
              panic_done_next   = 1'b1;
            end else if (!long_done && timer_ge(hold_timer, cfg.long_ms)) begin
              queued_event_next = EV_LONG;
              long_done_next    = 1'b1;
            end
          end else if (button_held && !down) begin
            button_held_next = 1'b0;
            if (!long_done && !panic_done && !very_long_done &&
                timer_ge(hold_timer, cfg.click_min_ms)) begin
              queued_event_next = EV_CLICK;
            end
          end
        end
        OP_TICK: begin
          if (button_held && hold_timer != TIMER_MAX) begin
            hold_timer_next = hold_timer + TIMER_ONE;
          end
        end
        OP_TAKE: begin
          event_res         = queued_event;
          queued_event_next = EV_NONE;
        end
        default: ;
      endcase
    end

    pressed  = button_held_next;
    press_ms = button_held_next ? sat16(hold_timer_next) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      queued_event   <= EV_NONE;
      button_held    <= 1'b0;
      hold_timer     <= '0;
      long_done      <= 1'b0;
      panic_done     <= 1'b0;
      very_long_done <= 1'b0;
    end else begin
      queued_event   <= queued_event_next;
      button_held    <= button_held_next;
      hold_timer     <= hold_timer_next;
      long_done      <= long_done_next;
      panic_done     <= panic_done_next;
      very_long_done <= very_long_done_next;
    end
  end

endmodule

[hdl/rotary_encoder_button_events_core.sv]
// Top level of the rotary encoder / button event block.
// Depends on reb_pkg, reb_turns, reb_button and the assertion macro header.
//
// Usage:
//  - Input channel (in_valid/in_ready) carries one command per transaction:
//    opcode 0 encoder sample (enc_a, enc_b), 1 poll (button_level, active low),
//    2 millisecond tick, 3 take the queued event.
//  - Output channel (out_valid/out_ready) returns exactly one result per
//    command: event_res (nonzero only for a take), pressed and press_ms as
//    they stand after the command.
//  - Path: an accepted command sits in the input register, is processed and
//    lands in the output register as soon as the output is free; its result
//    is valid from then on.
//  - Throughput: one command per cycle while out_ready stays high; the
//    next-state logic between the input and output registers is combinational.
//  - Stall: when out_ready is low with a result waiting, the input register
//    holds its command and in_ready drops once it is full; nothing is lost.
//  - Configuration: cfg_we/cfg_index/cfg_data write a threshold register;
//    write only while no command is in flight.
//  - Reset (rst, synchronous): thresholds return to 50/1000/3000/5000 ms,
//    encoder sits at detent, no pending turns, event slot empty, released.
`timescale 1ns / 1ps

`include "rotary_encoder_button_events_core_assert.svh"

module rotary_encoder_button_events_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    opcode,
  input  logic                          enc_a,
  input  logic                          enc_b,
  input  logic                          button_level,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    event_res,
  output logic                          pressed,
  output logic [15:0]                   press_ms,
  input  logic                          cfg_we,
  input  logic [reb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [reb_pkg::CFG_W-1:0]     cfg_data
);
  import reb_pkg::*;

  logic       s1_valid;
  logic [1:0] s1_opcode;
  logic       s1_enc_a, s1_enc_b, s1_button_level;
  logic       s1_adv;
  cmd_t       cmd;
  cfg_t       cfg;
  turn_stat_t stat;
  logic       consume;
  logic [2:0] event_next;
  logic       pressed_next;
  logic [15:0] press_ms_next;

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  assign cmd.fire         = s1_adv;
  assign cmd.opcode       = s1_opcode;
  assign cmd.enc_a        = s1_enc_a;
  assign cmd.enc_b        = s1_enc_b;
  assign cmd.button_level = s1_button_level;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_opcode       <= opcode;
      s1_enc_a        <= enc_a;
      s1_enc_b        <= enc_b;
      s1_button_level <= button_level;
    end
  end

  // threshold registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.click_min_ms <= CLICK_MIN_RST;
      cfg.long_ms      <= LONG_RST;
      cfg.panic_ms     <= PANIC_RST;
      cfg.very_long_ms <= VERY_LONG_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CLICK_MIN: cfg.click_min_ms <= cfg_data;
        CFG_LONG:      cfg.long_ms      <= cfg_data;
        CFG_PANIC:     cfg.panic_ms     <= cfg_data;
        CFG_VERY_LONG: cfg.very_long_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  reb_turns u_turns (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .consume (consume),
    .stat    (stat)
  );

  reb_button u_button (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg       (cfg),
    .stat      (stat),
    .consume   (consume),
    .event_res (event_next),
    .pressed   (pressed_next),
    .press_ms  (press_ms_next)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      event_res <= event_next;
      pressed   <= pressed_next;
      press_ms  <= press_ms_next;
    end
  end

  `REB_ASSERT(a_adv_fills_out, s1_adv |=> out_valid, "processed command did not reach output")
  `REB_ASSERT(a_stall_blocks_in, (s1_valid && out_valid && !out_ready) |-> !in_ready, "input taken while stalled and full")
  `REB_ASSERT(a_released_zero, (out_valid && !pressed) |-> (press_ms == '0), "press_ms nonzero while released")
  `REB_ASSERT(a_event_range, out_valid |-> (event_res <= EV_VERY_LONG), "event code out of range")
  `REB_ASSERT_RST(a_reset_empty, rst |=> (!out_valid && !s1_valid), "pipeline not empty after reset")

endmodule

[tb/rotary_encoder_button_events_core_tb.sv]
// Testbench for the rotary encoder / button event block: directed and random commands
// checked against an in-bench model of the decoder, the button classifier and the event slot.
// Depends on reb_pkg and rotary_encoder_button_events_core.
`timescale 1ns / 1ps

module rotary_encoder_button_events_core_tb;
  import reb_pkg::*;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int DRAIN_CYCLES = 4;

  typedef struct packed {
    logic [2:0]  ev;
    logic        held;
    logic [15:0] ms;
  } reb_status_t;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 in_valid     = 1'b0;
  logic                 in_ready;
  logic [1:0]           opcode       = OP_SAMPLE;
  logic                 enc_a        = 1'b1;
  logic                 enc_b        = 1'b1;
  logic                 button_level = 1'b1;
  logic                 out_valid;
  logic                 out_ready    = 1'b0;
  logic [2:0]           event_res;
  logic                 pressed;
  logic [15:0]          press_ms;
  logic                 cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = CFG_CLICK_MIN;
  logic [CFG_W-1:0]     cfg_data     = '0;

  int send_idle = 36;
  int recv_idle = 56;
  int err_cnt   = 0;
  int items_sent = 0;
  int cycle_cnt = 0;

  reb_status_t status_q[$];

  // model state
  logic [1:0]        m_phase;
  logic signed [7:0] m_steps;
  turns_t            m_turns;
  logic [2:0]        m_slot;
  logic              m_down;
  timer_t            m_hold;
  logic              m_long_seen, m_panic_seen, m_vlong_seen;
  logic [CFG_W-1:0]  th_click, th_long, th_panic, th_vlong;

  rotary_encoder_button_events_core uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .enc_a        (enc_a),
    .enc_b        (enc_b),
    .button_level (button_level),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_res    (event_res),
    .pressed      (pressed),
    .press_ms     (press_ms),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[rotary_encoder_button_events_core] ERROR");
      $finish;
    end
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle);

  // Gray phase to position on the clockwise ring 11 -> 01 -> 00 -> 10.
  function automatic int quad_step(input logic [1:0] from, input logic [1:0] to);
    logic [1:0] d;
    d = {~to[0], ^to} - {~from[0], ^from};
    if (d == 2'd1) return 1;
    if (d == 2'd3) return -1;
    return 0;
  endfunction

  function automatic reb_status_t predict_status(input logic [1:0] op, input logic a,
                                                 input logic b, input logic lvl);
    reb_status_t r;
    logic [1:0]  cur;
    int          acc;
    r.ev = EV_NONE;
    case (op)
      OP_SAMPLE: begin
        cur = {a, b};
        acc = int'(m_steps) + quad_step(m_phase, cur);
        if (acc > 127) acc = 127;
        else if (acc < -128) acc = -128;
        m_steps = 8'(acc);
        if (cur == PHASE_DETENT && m_phase != PHASE_DETENT) begin
          if (m_steps > 0 && m_turns != TURN_MAX) m_turns = m_turns + TURN_ONE;
          else if (m_steps < 0 && m_turns != TURN_MIN) m_turns = m_turns - TURN_ONE;
          m_steps = '0;
        end
        m_phase = cur;
      end
      OP_POLL: begin
        // a pending turn takes the empty slot and nothing else happens
        if (m_slot == EV_NONE && m_turns != '0) begin
          if (m_turns > 0) begin
            m_turns = m_turns - TURN_ONE;
            m_slot  = EV_CW;
          end else begin
            m_turns = m_turns + TURN_ONE;
            m_slot  = EV_CCW;
          end
        end else if (!lvl && !m_down) begin
          m_down       = 1'b1;
          m_hold       = '0;
          m_long_seen  = 1'b0;
          m_panic_seen = 1'b0;
          m_vlong_seen = 1'b0;
        end else if (!lvl) begin
          if (!m_vlong_seen && m_hold >= th_vlong) begin
            m_slot       = EV_VERY_LONG;
            m_vlong_seen = 1'b1;
          end else if (!m_panic_seen && m_hold >= th_panic) begin
            m_slot       = EV_PANIC;
            m_panic_seen = 1'b1;
          end else if (!m_long_seen && m_hold >= th_long) begin
            m_slot      = EV_LONG;
            m_long_seen = 1'b1;
          end
        end else if (m_down) begin
          m_down = 1'b0;
          if (!m_long_seen && !m_panic_seen && !m_vlong_seen && m_hold >= th_click)
            m_slot = EV_CLICK;
        end
      end
      OP_TICK: begin
        if (m_down && m_hold != TIMER_MAX) m_hold = m_hold + TIMER_ONE;
      end
      OP_TAKE: begin
        r.ev   = m_slot;
        m_slot = EV_NONE;
      end
    endcase
    r.held = m_down;
    r.ms   = !m_down ? 16'd0 : (32'(m_hold) > 32'hFFFF) ? 16'hFFFF : 16'(m_hold);
    return r;
  endfunction

  task automatic check_field(input string what, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
      err_cnt++;
    end
  endtask

  // model update and result checking
  always @(posedge clk) begin : monitor
    reb_status_t want;
    if (rst) begin
      m_phase      = PHASE_DETENT;
      m_steps      = '0;
      m_turns      = '0;
      m_slot       = EV_NONE;
      m_down       = 1'b0;
      m_hold       = '0;
      m_long_seen  = 1'b0;
      m_panic_seen = 1'b0;
      m_vlong_seen = 1'b0;
      th_click     = CLICK_MIN_RST;
      th_long      = LONG_RST;
      th_panic     = PANIC_RST;
      th_vlong     = VERY_LONG_RST;
    end else begin
      if (out_valid && out_ready) begin
        if (status_q.size() == 0) begin
          $display("%0t: result with nothing outstanding, expected none, got ev %0d %0b %0d",
                   $time, event_res, pressed, press_ms);
          err_cnt++;
        end else begin
          want = status_q.pop_front();
          check_field("event_res", 16'(want.ev), 16'(event_res));
          check_field("pressed", 16'(want.held), 16'(pressed));
          check_field("press_ms", want.ms, press_ms);
        end
      end
      if (in_valid && in_ready)
        status_q.push_back(predict_status(opcode, enc_a, enc_b, button_level));
      if (cfg_we) begin
        case (cfg_index)
          CFG_CLICK_MIN: th_click = cfg_data;
          CFG_LONG:      th_long  = cfg_data;
          CFG_PANIC:     th_panic = cfg_data;
          CFG_VERY_LONG: th_vlong = cfg_data;
        endcase
      end
    end
  end

  // One transaction; in_valid stays high afterward so the next one can follow directly.
  task automatic send_cmd(input logic [1:0] op, input logic a, input logic b,
                          input logic lvl);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    opcode       <= op;
    enc_a        <= a;
    enc_b        <= b;
    button_level <= lvl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic enc_phase(input logic [1:0] ph);
    send_cmd(OP_SAMPLE, ph[1], ph[0], 1'($urandom_range(1)));
  endtask

  task automatic poll_button(input logic lvl);
    send_cmd(OP_POLL, 1'($urandom_range(1)), 1'($urandom_range(1)), lvl);
  endtask

  task automatic ms_tick();
    send_cmd(OP_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)),
             1'($urandom_range(1)));
  endtask

  task automatic take_event();
    send_cmd(OP_TAKE, 1'($urandom_range(1)), 1'($urandom_range(1)),
             1'($urandom_range(1)));
  endtask

  task automatic turn_cw();
    enc_phase(2'b01);
    enc_phase(2'b00);
    enc_phase(2'b10);
    enc_phase(2'b11);
  endtask

  task automatic turn_ccw();
    enc_phase(2'b10);
    enc_phase(2'b00);
    enc_phase(2'b01);
    enc_phase(2'b11);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (status_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_W-1:0] c, input logic [CFG_W-1:0] l,
                           input logic [CFG_W-1:0] p, input logic [CFG_W-1:0] v);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [CFG_W-1:0]     val [4];
    idx = '{CFG_CLICK_MIN, CFG_LONG, CFG_PANIC, CFG_VERY_LONG};
    val = '{c, l, p, v};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_default_thresholds();
    repeat (3) ms_tick();      // released: timer must not move
    poll_button(1'b0);
    repeat (49) ms_tick();
    poll_button(1'b1);         // one short of click
    take_event();
    poll_button(1'b0);
    repeat (50) ms_tick();
    poll_button(1'b1);
    take_event();
  endtask

  // Runs with thresholds of 4, 10, 20 and 30 ms.
  task automatic test_hold_events();
    poll_button(1'b0);
    for (int t = 1; t <= 31; t++) begin
      ms_tick();
      if (t % 10 == 9 || t % 10 == 0) begin
        poll_button(1'b0);
        take_event();
      end
    end
    repeat (2) begin
      poll_button(1'b0);       // every hold event already raised
      take_event();
    end
    poll_button(1'b1);         // hold events seen, so no click
    take_event();
    poll_button(1'b0);
    repeat (3) ms_tick();
    poll_button(1'b1);         // one short of click
    take_event();
  endtask

  task automatic test_quadrature_decode();
    turn_cw();
    poll_button(1'b1);
    take_event();
    turn_ccw();
    poll_button(1'b1);
    take_event();
    // back to detent with zero net steps, resting at detent, illegal jump
    enc_phase(2'b01);
    enc_phase(2'b11);
    enc_phase(2'b11);
    enc_phase(2'b00);
    enc_phase(2'b11);
    poll_button(1'b1);
    take_event();
  endtask

  task automatic test_turn_before_button();
    turn_cw();
    turn_cw();
    poll_button(1'b0);         // only moves a turn into the slot
    poll_button(1'b0);         // slot busy: press is seen
    repeat (50) ms_tick();
    poll_button(1'b1);         // click overwrites the queued turn
    take_event();
    poll_button(1'b1);
    take_event();
  endtask

  // Each loop pass nets two steps, enough to push the accumulator past its limit.
  task automatic test_step_saturation();
    enc_phase(2'b01);
    repeat (70) begin
      enc_phase(2'b00);
      enc_phase(2'b10);
      enc_phase(2'b01);
    end
    enc_phase(2'b00);
    enc_phase(2'b10);
    enc_phase(2'b11);
    poll_button(1'b1);
    take_event();
    enc_phase(2'b10);
    repeat (70) begin
      enc_phase(2'b00);
      enc_phase(2'b01);
      enc_phase(2'b10);
    end
    enc_phase(2'b00);
    enc_phase(2'b01);
    enc_phase(2'b11);
    poll_button(1'b1);
    take_event();
  endtask

  task automatic test_random_traffic(input int n_items);
    int stop_at;
    int pick;
    int n;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          if ($urandom_range(7) == 0) enc_phase(2'($urandom_range(3)));   // bounce
          if ($urandom_range(1)) turn_cw();
          else turn_ccw();
        end
      end else if (pick < 70) begin
        poll_button(1'b0);
        n = $urandom_range(0, 30);
        repeat (n) begin
          ms_tick();
          if ($urandom_range(99) < 30) poll_button(1'b0);
          if ($urandom_range(99) < 15) take_event();
        end
        poll_button(1'b1);
        if ($urandom_range(1)) take_event();
      end else if (pick < 85) begin
        poll_button(1'($urandom_range(1)));
        take_event();
      end else begin
        repeat ($urandom_range(1, 4))
          send_cmd(2'($urandom_range(3)), 1'($urandom_range(1)),
                   1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_idle = 36;
    recv_idle = 56;
    test_default_thresholds();
    test_quadrature_decode();
    test_turn_before_button();
    wait_idle();
    write_cfg(16'd4, 16'd10, 16'd20, 16'd30);
    test_hold_events();
    wait_idle();
    write_cfg(16'($urandom_range(0, 12)), 16'($urandom_range(0, 25)),
              16'($urandom_range(0, 25)), 16'($urandom_range(0, 25)));
    test_random_traffic(250);
    wait_idle();

    send_idle = 56;
    recv_idle = 36;
    write_cfg(16'd0, 16'($urandom_range(0, 30)),
              16'($urandom_range(0, 30)), 16'($urandom_range(0, 30)));
    test_random_traffic(250);
    wait_idle();

    send_idle = 0;
    recv_idle = 0;
    test_step_saturation();
    wait_idle();
    write_cfg(16'hFFFF, 16'd0, 16'd0, 16'd0);
    test_random_traffic(220);
    wait_idle();

    if (err_cnt == 0) begin
      $display("[rotary_encoder_button_events_core] OK");
    end else begin
      $display("[rotary_encoder_button_events_core] ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/reb_pkg.sv
hdl/reb_turns.sv
hdl/reb_button.sv
hdl/rotary_encoder_button_events_core.sv
tb/rotary_encoder_button_events_core_tb.sv
